@@ rtl/ffha_pkg.sv @@
// Shared constants and codes for the first-fit heap allocator.
package ffha_pkg;
   localparam int DEFAULT_HEAP_BYTES = 4096;
   localparam int POS_W  = 34;
   localparam int SIZE_W = 32;
   localparam logic [2:0] HDR_LEN   = 3'd5;
   localparam logic [2:0] FIT_SLACK = 3'd6;
   localparam logic [7:0] FILL_BYTE = 8'h09;
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_ZERO_SIZE  = 3'd1;
   localparam logic [2:0] ST_FULL       = 3'd2;
   localparam logic [2:0] ST_NOT_INIT   = 3'd3;
   localparam logic [2:0] ST_BAD_ADDR   = 3'd4;
   localparam logic [2:0] ST_DOUBLE     = 3'd5;
   localparam logic [2:0] ST_BAD_HEADER = 3'd6;
   localparam logic [7:0] HDR_FREE = 8'd0;
   localparam logic [7:0] HDR_USED = 8'd1;
endpackage

@@ rtl/ffha_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ffha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ rtl/ffha_step_unit.sv @@
// Shared position adder: next header position from a base and a payload size.
module ffha_step_unit import ffha_pkg::*; (
   input  logic [POS_W-1:0]  base,
   input  logic [SIZE_W-1:0] size,
   output logic [POS_W-1:0]  next_pos
);
   assign next_pos = base + POS_W'(HDR_LEN) + POS_W'(size);
endmodule

@@ rtl/first_fit_heap_allocator_top.sv @@
// Top level of the first-fit heap allocator: sequencer, heap RAM and result register.
//
// Requests arrive on the req_ channel as one word: req_cmd selects allocate or free,
// req_alloc_size gives the payload bytes for allocate, req_free_offset the payload
// offset for free. Each request yields one rsp_ word with rsp_payload_offset and
// rsp_status.
// The heap lives in a single-port-write, single-port-read byte RAM, so every header
// is read and written byte by byte, and payload bytes are filled or cleared one at a
// time. An allocate walks the headers to the first fit, writes its header and, where
// there is room, the header that follows, then fills the payload bytes. A free reads
// the header and clears the payload bytes, then walks the heap twice, once to find a
// used block and once to merge free neighbours, with one header write and the absorbed
// block zeroed for each merge; a free that leaves no used block also sweeps the heap.
// One request is processed at a time; req_ready is high only while idle.
// After reset the block clears the heap RAM, one byte per cycle, and holds req_ready
// low meanwhile.
// A result is held in an output register; while the receiver stalls the block
// can accept and process the next request, and waits with its result until the
// register is free.
module first_fit_heap_allocator_top import ffha_pkg::*; #(
   parameter int HEAP_BYTES = DEFAULT_HEAP_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [11:0] req_alloc_size,
   input  logic [11:0] req_free_offset,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_payload_offset,
   output logic [2:0]  rsp_status
);
   localparam int AW = $clog2(HEAP_BYTES);
   localparam logic [POS_W-1:0] HEAP_P = POS_W'(HEAP_BYTES);
   localparam logic [POS_W-1:0] LAST_P = POS_W'(HEAP_BYTES - 1);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_RD, S_WR, S_FILL,
      S_A_CHK, S_A_EVAL, S_A_W2, S_A_FILL,
      S_F_EVAL, S_F_MARK,
      S_M1_CHK, S_M1_EVAL, S_M1_END,
      S_M2_CHK, S_M2_EVAL, S_M2_FILL,
      S_DONE
   } state_type;

   state_type         state_ff, after_ff;
   logic [2:0]        k_ff;
   logic [POS_W-1:0]  pos_ff, cur_ff, fend_ff, prev_pos_ff;
   logic [7:0]        st_ff, fval_ff;
   logic [SIZE_W-1:0] sz_ff, prev_sz_ff, wsz_ff;
   logic              wst_ff, hp_ff, any_ff, split_ff, heap_ready_ff, rd_oob_ff;
   logic [11:0]       req_ff, off_ff, res_off_ff, rsp_payload_offset_ff;
   logic [2:0]        res_st_ff, rsp_status_ff;
   logic              rsp_valid_ff;

   logic [POS_W-1:0]  acc_pos, next_pos, req_p;
   logic              in_heap, ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [7:0]        ram_wdata, ram_rdata, rbyte;

   ffha_step_unit u_step (
      .base     (cur_ff),
      .size     (sz_ff),
      .next_pos (next_pos)
   );

   ffha_ram #(.WIDTH(8), .DEPTH(HEAP_BYTES)) u_heap (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (acc_pos[AW-1:0]),
      .rdata (ram_rdata)
   );

   assign acc_pos = pos_ff + POS_W'(k_ff);
   assign in_heap = acc_pos < HEAP_P;
   assign rbyte   = rd_oob_ff ? 8'd0 : ram_rdata;
   assign req_p   = POS_W'(req_ff);

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = acc_pos[AW-1:0];
      ram_wdata = 8'd0;
      unique case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = cur_ff[AW-1:0];
         end
         S_WR: begin
            ram_we = in_heap;
            case (k_ff)
               3'd0:    ram_wdata = {7'd0, wst_ff};
               3'd1:    ram_wdata = wsz_ff[31:24];
               3'd2:    ram_wdata = wsz_ff[23:16];
               3'd3:    ram_wdata = wsz_ff[15:8];
               default: ram_wdata = wsz_ff[7:0];
            endcase
         end
         S_FILL: begin
            ram_we    = in_heap && (acc_pos < fend_ff);
            ram_wdata = fval_ff;
         end
         S_F_MARK: begin
            ram_we    = 1'b1;
            ram_waddr = AW'(POS_W'(off_ff) - POS_W'(HDR_LEN));
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      rd_oob_ff <= !in_heap;
      if (reset) begin
         state_ff      <= S_CLEAR;
         cur_ff        <= '0;
         heap_ready_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         k_ff          <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               cur_ff <= cur_ff + POS_W'(1);
               if (cur_ff == LAST_P) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  req_ff   <= req_alloc_size;
                  off_ff   <= req_free_offset;
                  res_off_ff <= '0;
                  k_ff     <= '0;
                  if (req_cmd == CMD_ALLOC) begin
                     heap_ready_ff <= 1'b1;
                     if (req_alloc_size == 12'd0) begin
                        res_st_ff <= ST_ZERO_SIZE;
                        state_ff  <= S_DONE;
                     end else begin
                        cur_ff   <= POS_W'(1);
                        state_ff <= S_A_CHK;
                     end
                  end else if (!heap_ready_ff) begin
                     res_st_ff <= ST_NOT_INIT;
                     state_ff  <= S_DONE;
                  end else if (req_free_offset < 12'd6 ||
                               POS_W'(req_free_offset) >= HEAP_P) begin
                     res_st_ff <= ST_BAD_ADDR;
                     state_ff  <= S_DONE;
                  end else begin
                     pos_ff   <= POS_W'(req_free_offset) - POS_W'(HDR_LEN);
                     after_ff <= S_F_EVAL;
                     state_ff <= S_RD;
                  end
               end
            end
            S_RD: begin
               if (k_ff == 3'd1) begin
                  st_ff <= rbyte;
               end else if (k_ff != 3'd0) begin
                  sz_ff <= {sz_ff[23:0], rbyte};
               end
               if (k_ff == 3'd5) begin
                  k_ff     <= '0;
                  state_ff <= after_ff;
               end else begin
                  k_ff <= k_ff + 3'd1;
               end
            end
            S_WR: begin
               if (k_ff == 3'd4) begin
                  k_ff     <= '0;
                  state_ff <= after_ff;
               end else begin
                  k_ff <= k_ff + 3'd1;
               end
            end
            S_FILL: begin
               if (!in_heap || acc_pos >= fend_ff) begin
                  state_ff <= after_ff;
               end else begin
                  pos_ff <= pos_ff + POS_W'(1);
               end
            end
            S_A_CHK: begin
               if (cur_ff + POS_W'(4) > LAST_P) begin
                  res_st_ff <= ST_FULL;
                  state_ff  <= S_DONE;
               end else begin
                  pos_ff   <= cur_ff;
                  after_ff <= S_A_EVAL;
                  state_ff <= S_RD;
               end
            end
            S_A_EVAL: begin
               if (st_ff == HDR_USED || (st_ff == HDR_FREE && sz_ff != '0 &&
                   req_p + POS_W'(FIT_SLACK) > POS_W'(sz_ff))) begin
                  if (next_pos > LAST_P) begin
                     res_st_ff <= ST_FULL;
                     state_ff  <= S_DONE;
                  end else begin
                     cur_ff   <= next_pos;
                     state_ff <= S_A_CHK;
                  end
               end else if (st_ff == HDR_FREE && sz_ff != '0) begin
                  split_ff <= 1'b1;
                  pos_ff   <= cur_ff;
                  wst_ff   <= 1'b1;
                  wsz_ff   <= SIZE_W'(req_ff);
                  after_ff <= S_A_W2;
                  state_ff <= S_WR;
               end else if (cur_ff + POS_W'(4) + req_p > LAST_P) begin
                  res_st_ff <= ST_FULL;
                  state_ff  <= S_DONE;
               end else begin
                  split_ff <= 1'b0;
                  pos_ff   <= cur_ff;
                  wst_ff   <= 1'b1;
                  wsz_ff   <= SIZE_W'(req_ff);
                  after_ff <= S_A_W2;
                  state_ff <= S_WR;
               end
            end
            S_A_W2: begin
               pos_ff   <= cur_ff + POS_W'(HDR_LEN) + req_p;
               wst_ff   <= 1'b0;
               after_ff <= S_A_FILL;
               if (split_ff) begin
                  wsz_ff   <= sz_ff - SIZE_W'(req_ff) - SIZE_W'(HDR_LEN);
                  state_ff <= S_WR;
               end else if (cur_ff + POS_W'(10) + req_p <= LAST_P) begin
                  wsz_ff   <= '0;
                  state_ff <= S_WR;
               end else begin
                  state_ff <= S_A_FILL;
               end
            end
            S_A_FILL: begin
               pos_ff     <= cur_ff + POS_W'(HDR_LEN);
               fend_ff    <= cur_ff + POS_W'(HDR_LEN) + req_p;
               fval_ff    <= FILL_BYTE;
               res_off_ff <= 12'(cur_ff + POS_W'(HDR_LEN));
               res_st_ff  <= ST_OK;
               after_ff   <= S_DONE;
               state_ff   <= S_FILL;
            end
            S_F_EVAL: begin
               if (st_ff == HDR_FREE) begin
                  res_st_ff <= ST_DOUBLE;
                  state_ff  <= S_DONE;
               end else if (st_ff != HDR_USED) begin
                  res_st_ff <= ST_BAD_HEADER;
                  state_ff  <= S_DONE;
               end else begin
                  pos_ff   <= POS_W'(off_ff);
                  fend_ff  <= POS_W'(off_ff) + POS_W'(sz_ff);
                  fval_ff  <= 8'd0;
                  after_ff <= S_F_MARK;
                  state_ff <= S_FILL;
               end
            end
            S_F_MARK: begin
               cur_ff   <= POS_W'(1);
               any_ff   <= 1'b0;
               state_ff <= S_M1_CHK;
            end
            S_M1_CHK: begin
               if (cur_ff < LAST_P) begin
                  pos_ff   <= cur_ff;
                  after_ff <= S_M1_EVAL;
                  state_ff <= S_RD;
               end else begin
                  state_ff <= S_M1_END;
               end
            end
            S_M1_EVAL: begin
               if (st_ff == HDR_USED) begin
                  any_ff   <= 1'b1;
                  state_ff <= S_M1_END;
               end else if (cur_ff + POS_W'(4) > LAST_P) begin
                  state_ff <= S_M1_END;
               end else begin
                  cur_ff   <= next_pos;
                  state_ff <= S_M1_CHK;
               end
            end
            S_M1_END: begin
               cur_ff <= POS_W'(1);
               hp_ff  <= 1'b0;
               if (!any_ff) begin
                  pos_ff   <= POS_W'(1);
                  fend_ff  <= HEAP_P;
                  fval_ff  <= 8'd0;
                  after_ff <= S_M2_CHK;
                  state_ff <= S_FILL;
               end else begin
                  state_ff <= S_M2_CHK;
               end
            end
            S_M2_CHK: begin
               if (cur_ff + POS_W'(4) > LAST_P) begin
                  res_st_ff <= ST_OK;
                  state_ff  <= S_DONE;
               end else begin
                  pos_ff   <= cur_ff;
                  after_ff <= S_M2_EVAL;
                  state_ff <= S_RD;
               end
            end
            S_M2_EVAL: begin
               if (st_ff == HDR_FREE) begin
                  if (!hp_ff) begin
                     hp_ff       <= 1'b1;
                     prev_pos_ff <= cur_ff;
                     prev_sz_ff  <= sz_ff;
                     cur_ff      <= next_pos;
                     state_ff    <= S_M2_CHK;
                  end else begin
                     pos_ff     <= prev_pos_ff;
                     wst_ff     <= 1'b0;
                     wsz_ff     <= prev_sz_ff + sz_ff + SIZE_W'(HDR_LEN);
                     prev_sz_ff <= prev_sz_ff + sz_ff + SIZE_W'(HDR_LEN);
                     after_ff   <= S_M2_FILL;
                     state_ff   <= S_WR;
                  end
               end else begin
                  hp_ff    <= 1'b0;
                  cur_ff   <= next_pos;
                  state_ff <= S_M2_CHK;
               end
            end
            S_M2_FILL: begin
               pos_ff   <= cur_ff;
               fend_ff  <= next_pos;
               cur_ff   <= next_pos;
               fval_ff  <= 8'd0;
               after_ff <= S_M2_CHK;
               state_ff <= S_FILL;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff          <= 1'b1;
                  rsp_payload_offset_ff <= res_off_ff;
                  rsp_status_ff         <= res_st_ff;
                  state_ff              <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // The first free header of a run keeps its position in prev_pos_ff, and each
   // merge rewrites that header while the walk moves on past the absorbed block.

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_payload_offset = rsp_payload_offset_ff;
   assign rsp_status         = rsp_status_ff;

   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req_ready)
      else $error("request taken during heap clear");

   a_offset_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_offset_ff != 12'd0 |-> rsp_status_ff == ST_OK)
      else $error("payload offset given without ok status");

   a_free_before_init: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd == CMD_FREE && !heap_ready_ff
      |=> state_ff == S_DONE && res_st_ff == ST_NOT_INIT)
      else $error("free before init not rejected");
endmodule
